>>> rtl/core/delimited_lexer_token_classifier_macros.svh
// Assertion helpers for the lexer core.
`ifndef DELIMITED_LEXER_TOKEN_CLASSIFIER_MACROS_SVH
`define DELIMITED_LEXER_TOKEN_CLASSIFIER_MACROS_SVH

// Same-cycle implication, disabled during reset
`define DLX_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define DLX_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/dlx_pkg.sv
package dlx_pkg;

  localparam int unsigned MAX_TOKEN_LEN_DEF = 255;
  localparam int unsigned QUEUE_DEPTH_DEF   = 4;

  typedef enum logic [2:0] {
    CLS_KEYWORD = 3'd0,
    CLS_IDENT   = 3'd1,
    CLS_OPER    = 3'd2,
    CLS_SEP     = 3'd3,
    CLS_PAREN   = 3'd4,
    CLS_NUMBER  = 3'd5,
    CLS_OTHER   = 3'd6
  } tok_class_e;

  // Keyword lengths
  localparam logic [15:0] KW_IF_LEN    = 16'd2;
  localparam logic [15:0] KW_ELSE_LEN  = 16'd4;
  localparam logic [15:0] KW_WHILE_LEN = 16'd5;

  // One queue entry: up to two results caused by one input item
  typedef struct packed {
    logic       tok_vld;
    tok_class_e tok_class;
    logic [31:0] tok_start;
    logic [7:0] tok_len;
    logic       tok_sat;
    logic       sep_vld;
    logic [31:0] sep_start;
  } dlx_entry_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'd32) || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

  function automatic logic is_sep(input logic [7:0] c);
    return (c == ";") || (c == ",") || (c == "=");
  endfunction

  function automatic tok_class_e class_of_first(input logic [7:0] c);
    tok_class_e cls;
    if (((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"))) begin
      cls = CLS_IDENT;
    end else if ((c == "+") || (c == "-") || (c == "*") || (c == "/")) begin
      cls = CLS_OPER;
    end else if ((c == "(") || (c == ")") || (c == "{") || (c == "}")) begin
      cls = CLS_PAREN;
    end else if ((c == ",") || (c == ";")) begin
      cls = CLS_SEP;
    end else if ((c >= "0") && (c <= "9")) begin
      cls = CLS_NUMBER;
    end else begin
      cls = CLS_OTHER;
    end
    return cls;
  endfunction

  // Per-byte keyword match: bit0 if, bit1 else, bit2 while
  function automatic logic [2:0] kw_match(input logic [15:0] p, input logic [7:0] c);
    logic [2:0] m;
    m[0] = ((p == 16'd0) && (c == "i")) || ((p == 16'd1) && (c == "f"));
    m[1] = ((p == 16'd0) && (c == "e")) || ((p == 16'd1) && (c == "l")) ||
           ((p == 16'd2) && (c == "s")) || ((p == 16'd3) && (c == "e"));
    m[2] = ((p == 16'd0) && (c == "w")) || ((p == 16'd1) && (c == "h")) ||
           ((p == 16'd2) && (c == "i")) || ((p == 16'd3) && (c == "l")) ||
           ((p == 16'd4) && (c == "e"));
    return m;
  endfunction

endpackage

>>> rtl/core/dlx_front.sv
module dlx_front import dlx_pkg::*; #(
  parameter int unsigned MaxTokenLen = MAX_TOKEN_LEN_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] text_byte_i,
  input  logic       flush_i,
  output logic       push_valid_o,
  input  logic       push_ready_i,
  output dlx_entry_t push_data_o
);

  localparam int unsigned LenW = $clog2(MaxTokenLen + 1);

  logic [31:0]     byte_pos_q, byte_pos_d;
  logic [LenW-1:0] pend_len_q, pend_len_d;
  logic [31:0]     pend_start_q, pend_start_d;
  tok_class_e      first_cls_q, first_cls_d;
  logic [2:0]      kw_flags_q, kw_flags_d;
  logic            ovf_q, ovf_d;

  logic        acc;
  logic        sp, sep, delim, has_pend, tok_emit, sep_emit;
  logic [15:0] len_ext;
  logic        is_kw;

  assign in_ready_o = push_ready_i;
  assign acc        = in_valid_i && push_ready_i;

  // Byte decode
  assign sp       = is_space(text_byte_i);
  assign sep      = is_sep(text_byte_i);
  assign delim    = !flush_i && (sp || sep);
  assign has_pend = (pend_len_q != '0);
  assign tok_emit = (flush_i || delim) && has_pend;
  assign sep_emit = !flush_i && sep;
  assign len_ext  = 16'(pend_len_q);

  // Token result from the pending state
  assign is_kw = (kw_flags_q[0] && (len_ext == KW_IF_LEN))   ||
                 (kw_flags_q[1] && (len_ext == KW_ELSE_LEN)) ||
                 (kw_flags_q[2] && (len_ext == KW_WHILE_LEN));

  always_comb begin
    push_data_o.tok_vld   = tok_emit;
    push_data_o.tok_class = is_kw ? CLS_KEYWORD : first_cls_q;
    push_data_o.tok_start = pend_start_q;
    push_data_o.tok_len   = (len_ext > 16'd255) ? 8'd255 : len_ext[7:0];
    push_data_o.tok_sat   = ovf_q || (len_ext > 16'd255);
    push_data_o.sep_vld   = sep_emit;
    push_data_o.sep_start = byte_pos_q;
  end

  assign push_valid_o = acc && (tok_emit || sep_emit);

  // Pending token and position update
  always_comb begin
    byte_pos_d   = byte_pos_q;
    pend_len_d   = pend_len_q;
    pend_start_d = pend_start_q;
    first_cls_d  = first_cls_q;
    kw_flags_d   = kw_flags_q;
    ovf_d        = ovf_q;
    if (acc) begin
      if (flush_i || delim) begin
        if (has_pend) begin
          pend_len_d   = '0;
          pend_start_d = '0;
          first_cls_d  = CLS_KEYWORD;
          kw_flags_d   = 3'b111;
          ovf_d        = 1'b0;
        end
        if (delim) begin
          byte_pos_d = byte_pos_q + 32'd1;
        end
      end else begin
        if (!has_pend) begin
          pend_start_d = byte_pos_q;
          first_cls_d  = class_of_first(text_byte_i);
        end
        kw_flags_d = kw_flags_q & kw_match(len_ext, text_byte_i);
        if (pend_len_q < LenW'(MaxTokenLen)) begin
          pend_len_d = pend_len_q + LenW'(1);
        end else begin
          ovf_d = 1'b1;
        end
        byte_pos_d = byte_pos_q + 32'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_pos_q   <= '0;
      pend_len_q   <= '0;
      pend_start_q <= '0;
      first_cls_q  <= CLS_KEYWORD;
      kw_flags_q   <= 3'b111;
      ovf_q        <= 1'b0;
    end else begin
      byte_pos_q   <= byte_pos_d;
      pend_len_q   <= pend_len_d;
      pend_start_q <= pend_start_d;
      first_cls_q  <= first_cls_d;
      kw_flags_q   <= kw_flags_d;
      ovf_q        <= ovf_d;
    end
  end

endmodule

>>> rtl/core/dlx_queue.sv
module dlx_queue import dlx_pkg::*; #(
  parameter int unsigned Depth = QUEUE_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_valid_i,
  output logic       push_ready_o,
  input  dlx_entry_t push_data_i,
  output logic       pop_valid_o,
  input  logic       pop_ready_i,
  output dlx_entry_t pop_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  dlx_entry_t      mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push, pop;

  assign push_ready_o = (cnt_q != CntW'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  // Pointer and fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

>>> rtl/core/dlx_back.sv
module dlx_back import dlx_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        pop_valid_i,
  output logic        pop_ready_o,
  input  dlx_entry_t  pop_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  token_class_o,
  output logic [31:0] token_start_o,
  output logic [7:0]  token_length_o,
  output logic        length_saturated_o,
  output logic        last_of_run_o
);

  dlx_entry_t ent_q, ent_d;
  logic       ent_vld_q, ent_vld_d;
  logic       phase_q, phase_d;
  logic       show_tok, both, xfer, done, load;

  assign show_tok = ent_q.tok_vld && !phase_q;
  assign both     = ent_q.tok_vld && ent_q.sep_vld;
  assign xfer     = ent_vld_q && out_ready_i;
  assign done     = xfer && !(both && !phase_q);
  assign load     = pop_valid_i && pop_ready_o;

  assign pop_ready_o = !ent_vld_q || done;

  // Result select: token first, separator after it
  assign out_valid_o        = ent_vld_q;
  assign token_class_o      = show_tok ? ent_q.tok_class : CLS_SEP;
  assign token_start_o      = show_tok ? ent_q.tok_start : ent_q.sep_start;
  assign token_length_o     = show_tok ? ent_q.tok_len : 8'd1;
  assign length_saturated_o = show_tok && ent_q.tok_sat;
  assign last_of_run_o      = show_tok ? !ent_q.sep_vld : 1'b1;

  always_comb begin
    ent_d     = ent_q;
    ent_vld_d = ent_vld_q;
    phase_d   = phase_q;
    if (load) begin
      ent_d     = pop_data_i;
      ent_vld_d = 1'b1;
      phase_d   = 1'b0;
    end else if (done) begin
      ent_vld_d = 1'b0;
      phase_d   = 1'b0;
    end else if (xfer) begin
      phase_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_vld_q <= 1'b0;
      phase_q   <= 1'b0;
    end else begin
      ent_vld_q <= ent_vld_d;
      phase_q   <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

endmodule

>>> rtl/core/delimited_lexer_token_classifier.sv
// Byte-stream lexer: takes one text byte (or an end-of-text flush) per transfer and
// reports each finished token by class, start offset and length, followed by a
// separator result for every ';', ',' or '='. Input transfers are taken one per
// cycle while the queue has room; results leave one per cycle while out_ready_i is
// high, so an item that closes a token on a separator yields two results. The
// classifier and the output stage are decoupled by a queue of QueueDepth entries,
// each holding all results of one item; in_ready_o drops only while it is full.
// A result is stored in the queue, then in the output register, before it shows.
`include "delimited_lexer_token_classifier_macros.svh"

module delimited_lexer_token_classifier import dlx_pkg::*; #(
  parameter int unsigned MaxTokenLen = MAX_TOKEN_LEN_DEF,
  parameter int unsigned QueueDepth  = QUEUE_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  text_byte_i,
  input  logic        flush_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  token_class_o,
  output logic [31:0] token_start_o,
  output logic [7:0]  token_length_o,
  output logic        length_saturated_o,
  output logic        last_of_run_o
);

  logic       push_valid, push_ready, pop_valid, pop_ready;
  dlx_entry_t push_data, pop_data;

  // Classifier
  dlx_front #(
    .MaxTokenLen(MaxTokenLen)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .text_byte_i (text_byte_i),
    .flush_i     (flush_i),
    .push_valid_o(push_valid),
    .push_ready_i(push_ready),
    .push_data_o (push_data)
  );

  // Decoupling queue
  dlx_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_data_i (push_data),
    .pop_valid_o (pop_valid),
    .pop_ready_i (pop_ready),
    .pop_data_o  (pop_data)
  );

  // Result sequencer
  dlx_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .pop_valid_i       (pop_valid),
    .pop_ready_o       (pop_ready),
    .pop_data_i        (pop_data),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .token_class_o     (token_class_o),
    .token_start_o     (token_start_o),
    .token_length_o    (token_length_o),
    .length_saturated_o(length_saturated_o),
    .last_of_run_o     (last_of_run_o)
  );

  // Checks
  `DLX_ASSERT_NOW(a_sep_shape, clk_i, rst_ni, out_valid_o && (token_class_o == CLS_SEP), (token_length_o == 8'd1) && !length_saturated_o && last_of_run_o, "separator result malformed")
  `DLX_ASSERT_NEXT(a_second_follows, clk_i, rst_ni, out_valid_o && out_ready_i && !last_of_run_o, out_valid_o && (token_class_o == CLS_SEP), "separator missing after token")
  `DLX_ASSERT_NOW(a_len_nonzero, clk_i, rst_ni, out_valid_o, token_length_o != 8'd0, "zero length result")
  `DLX_ASSERT_NOW(a_full_has_data, clk_i, rst_ni, !push_ready, pop_valid, "queue full yet empty")

endmodule

>>> dv/tb.sv
module tb;
  import dlx_pkg::*;

  localparam int unsigned MAX_LEN     = MAX_TOKEN_LEN_DEF;
  localparam int unsigned TOTAL_ITEMS = 1850;
  localparam int unsigned LONG_HOLD   = 400;
  localparam int unsigned TAIL_CYCLES = 8;
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned MAX_REPORTS = 50;

  // Keyword slots, same order as the match flags
  localparam int KW_IF    = 0;
  localparam int KW_ELSE  = 1;
  localparam int KW_WHILE = 2;

  typedef enum int {RX_OPEN, RX_COIN, RX_PERIODIC, RX_SPARSE} rx_mode_e;

  typedef struct {
    tok_class_e  cls;
    logic [31:0] start;
    logic [7:0]  len;
    logic        sat;
    logic        last;
  } token_rec_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  logic [7:0]  text_byte_i = 8'd0;
  logic        flush_i     = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [2:0]  token_class_o;
  logic [31:0] token_start_o;
  logic [7:0]  token_length_o;
  logic        length_saturated_o;
  logic        last_of_run_o;

  bit          hold_off_req = 1'b0;
  int unsigned items_sent   = 0;
  int unsigned burst_left   = 0;

  delimited_lexer_token_classifier u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .text_byte_i        (text_byte_i),
    .flush_i            (flush_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .token_class_o      (token_class_o),
    .token_start_o      (token_start_o),
    .token_length_o     (token_length_o),
    .length_saturated_o (length_saturated_o),
    .last_of_run_o      (last_of_run_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic is_blank(input logic [7:0] c);
    return (c == 8'd32) || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

  function automatic logic is_separator(input logic [7:0] c);
    return (c == ";") || (c == ",") || (c == "=");
  endfunction

  // Tracks the lexer state and holds the token results still to come
  class token_tracker;
    token_rec_t  due_tokens[$];
    int unsigned err_count;
    logic [31:0] next_pos;
    logic [31:0] tok_start;
    int unsigned tok_len;
    tok_class_e  lead_cls;
    logic [2:0]  kw_live;
    logic        clipped;

    function new();
      err_count = 0;
      next_pos  = '0;
      clear_token();
    endfunction

    function void clear_token();
      tok_len   = 0;
      tok_start = '0;
      lead_cls  = CLS_KEYWORD;
      kw_live   = 3'b111;
      clipped   = 1'b0;
    endfunction

    function string kw_word(input int idx);
      case (idx)
        KW_IF:   return "if";
        KW_ELSE: return "else";
        default: return "while";
      endcase
    endfunction

    function tok_class_e lead_class(input logic [7:0] c);
      if (((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"))) return CLS_IDENT;
      if ((c == "+") || (c == "-") || (c == "*") || (c == "/")) return CLS_OPER;
      if ((c == "(") || (c == ")") || (c == "{") || (c == "}")) return CLS_PAREN;
      if ((c == ",") || (c == ";")) return CLS_SEP;
      if ((c >= "0") && (c <= "9")) return CLS_NUMBER;
      return CLS_OTHER;
    endfunction

    // Close the pending token: keyword needs live flags and the exact length
    function void close_token();
      token_rec_t r;
      string      w;
      int         i;
      r.cls = lead_cls;
      for (i = KW_IF; i <= KW_WHILE; i++) begin
        w = kw_word(i);
        if (kw_live[i] && (tok_len == w.len())) r.cls = CLS_KEYWORD;
      end
      r.start = tok_start;
      r.len   = (tok_len > 255) ? 8'd255 : 8'(tok_len);
      r.sat   = clipped || (tok_len > 255);
      r.last  = 1'b0;
      due_tokens.push_back(r);
      clear_token();
    endfunction

    // One accepted input transfer
    function void take_byte(input logic [7:0] c, input logic fl);
      int unsigned first;
      int          i;
      string       w;
      first = due_tokens.size();
      if (fl) begin
        if (tok_len > 0) close_token();
      end else if (is_blank(c) || is_separator(c)) begin
        if (tok_len > 0) close_token();
        if (is_separator(c)) begin
          due_tokens.push_back('{cls: CLS_SEP, start: next_pos, len: 8'd1,
                                 sat: 1'b0, last: 1'b0});
        end
        next_pos++;
      end else begin
        if (tok_len == 0) begin
          tok_start = next_pos;
          lead_cls  = lead_class(c);
        end
        for (i = KW_IF; i <= KW_WHILE; i++) begin
          w = kw_word(i);
          if ((tok_len >= w.len()) || (w[tok_len] != c)) kw_live[i] = 1'b0;
        end
        if (tok_len < MAX_LEN) tok_len++;
        else clipped = 1'b1;
        next_pos++;
      end
      if (due_tokens.size() > first) due_tokens[$].last = 1'b1;
    endfunction

    task report(input string msg);
      err_count++;
      if (err_count <= MAX_REPORTS) $display("mismatch: %s", msg);
    endtask

    // One accepted result transfer, against the oldest due token
    task check_token(input logic [2:0] cls, input logic [31:0] start,
                     input logic [7:0] len, input logic sat, input logic last);
      token_rec_t r;
      if (due_tokens.size() == 0) begin
        report($sformatf("unexpected result: class %0d start %0d len %0d",
                         cls, start, len));
      end else begin
        r = due_tokens.pop_front();
        if (cls !== r.cls)
          report($sformatf("start %0d: class %0d, want %0d", r.start, cls, r.cls));
        if (start !== r.start)
          report($sformatf("start %0d, want %0d", start, r.start));
        if (len !== r.len)
          report($sformatf("start %0d: length %0d, want %0d", r.start, len, r.len));
        if (sat !== r.sat)
          report($sformatf("start %0d: saturated %0b, want %0b", r.start, sat, r.sat));
        if (last !== r.last)
          report($sformatf("start %0d: last %0b, want %0b", r.start, last, r.last));
      end
    endtask
  endclass

  token_tracker tracker = new();

  // Sample both channels at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) tracker.take_byte(text_byte_i, flush_i);
      if (out_valid_o && out_ready_i) begin
        tracker.check_token(token_class_o, token_start_o, token_length_o,
                            length_saturated_o, last_of_run_o);
      end
    end
  end

  // Receiver: own stall pattern, plus one long hold-off on request
  initial begin : receiver
    rx_mode_e    mode;
    int unsigned mode_left;
    int unsigned tick;
    mode      = RX_OPEN;
    mode_left = 0;
    tick      = 0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk_i);
      end else begin
        if (mode_left == 0) begin
          mode      = rx_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        tick++;
        case (mode)
          RX_OPEN:     out_ready_i <= 1'b1;
          RX_COIN:     out_ready_i <= ($urandom_range(0, 1) == 1);
          RX_PERIODIC: out_ready_i <= ((tick % 3) != 0);
          default:     out_ready_i <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Ends the run when no transfer happens on either channel for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Offer one item; bursts of random length with random gaps between them
  task automatic send_item(input logic [7:0] b, input logic fl);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i  <= 1'b1;
    text_byte_i <= b;
    flush_i     <= fl;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  // Stop offering and wait until every due token has arrived
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (tracker.due_tokens.size() != 0) @(negedge clk_i);
    repeat (TAIL_CYCLES) @(negedge clk_i);
  endtask

  function automatic logic [7:0] rand_letter();
    return ($urandom_range(0, 1) == 1) ? 8'("a" + $urandom_range(0, 25))
                                       : 8'("A" + $urandom_range(0, 25));
  endfunction

  // Any byte that does not end a token
  function automatic logic [7:0] rand_body_byte();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    while (is_blank(c) || is_separator(c)) c = 8'($urandom_range(0, 255));
    return c;
  endfunction

  task automatic send_delimiter();
    int unsigned n;
    int unsigned d;
    string       seps;
    seps = ";,=";
    n = ($urandom_range(0, 5) == 0) ? 2 : 1;
    repeat (n) begin
      d = $urandom_range(0, 9);
      if (d <= 5) send_item((d == 5) ? 8'd32 : 8'(9 + $urandom_range(0, 4)), 1'b0);
      else if (d <= 8) send_item(seps[$urandom_range(0, 2)], 1'b0);
      else send_item(8'($urandom_range(0, 255)), 1'b1);
    end
  endtask

  // Exact keywords and near misses: cut short, extended, one letter changed
  task automatic send_keyword_like();
    string       w;
    string       t;
    int unsigned p;
    case ($urandom_range(0, 2))
      0:       w = "if";
      1:       w = "else";
      default: w = "while";
    endcase
    case ($urandom_range(0, 5))
      0: w = w.substr(0, w.len() - 2);
      1: begin
        t    = " ";
        t[0] = rand_letter();
        w    = {w, t};
      end
      2: begin
        p    = $urandom_range(0, w.len() - 1);
        w[p] = rand_letter();
      end
      default: ;
    endcase
    send_text(w);
  endtask

  task automatic send_plain_token();
    int unsigned n;
    string       ops;
    string       parens;
    ops    = "+-*/";
    parens = "(){}";
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 20) : $urandom_range(1, 5);
    case ($urandom_range(0, 4))
      0:       send_item(rand_letter(), 1'b0);
      1:       send_item(ops[$urandom_range(0, 3)], 1'b0);
      2:       send_item(parens[$urandom_range(0, 3)], 1'b0);
      3:       send_item(8'("0" + $urandom_range(0, 9)), 1'b0);
      default: send_item(rand_body_byte(), 1'b0);
    endcase
    repeat (n - 1) begin
      if ($urandom_range(0, 4) < 3) begin
        send_item(($urandom_range(0, 1) == 1) ? rand_letter()
                                              : 8'("0" + $urandom_range(0, 9)), 1'b0);
      end else begin
        send_item(rand_body_byte(), 1'b0);
      end
    end
  endtask

  task automatic send_long_token(input int unsigned n);
    repeat (n) send_item(rand_letter(), 1'b0);
  endtask

  // Mostly well-formed tokens and delimiters, some raw noise
  task automatic send_random_word();
    int unsigned kind;
    kind = $urandom_range(0, 299);
    if (kind < 30) begin
      repeat ($urandom_range(1, 8)) begin
        send_item(8'($urandom_range(0, 255)), $urandom_range(0, 5) == 0);
      end
    end else begin
      if (kind < 32) send_long_token($urandom_range(MAX_LEN - 3, MAX_LEN + 20));
      else if (kind < 110) send_keyword_like();
      else send_plain_token();
      send_delimiter();
    end
  endtask

  initial begin : stimulus
    bit hold_done;
    bit pause_done;
    hold_done  = 1'b0;
    pause_done = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Keywords, a separator right after a token and one with nothing pending
    send_text("if else;while=");
    send_text(";");
    // Flush with nothing pending; its byte is ignored
    send_item(8'hFF, 1'b1);
    // Operator, parenthesis and number, closed by assorted whitespace
    send_text("+");
    send_item(8'd9, 1'b0);
    send_text("(");
    send_item(8'd11, 1'b0);
    send_text("7");
    send_item(8'd12, 1'b0);
    // High and zero bytes class as other; closed by flush
    send_item(8'h80, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b1);
    wait_drained();

    // Longest unclipped token, then one past the limit
    send_long_token(MAX_LEN);
    send_delimiter();
    send_long_token(MAX_LEN + $urandom_range(1, 40));
    send_delimiter();

    while (items_sent < TOTAL_ITEMS) begin
      if (!hold_done && (items_sent >= 600)) begin
        hold_off_req = 1'b1;
        hold_done    = 1'b1;
      end
      if (!pause_done && (items_sent >= 1200)) begin
        wait_drained();
        pause_done = 1'b1;
      end
      send_random_word();
    end

    wait_drained();
    if (tracker.err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/dlx_pkg.sv
rtl/core/dlx_front.sv
rtl/core/dlx_queue.sv
rtl/core/dlx_back.sv
rtl/core/delimited_lexer_token_classifier.sv
dv/tb.sv
